// ===== hw/rtl/oras_pkg.sv =====
// Shared types and constants for the outlier-rejecting sample averager.
package oras_pkg;

  // Field widths of the sample and result items.
  localparam int SAMPLE_W  = 16;
  localparam int CHANNEL_W = 2;
  localparam int COUNT_W   = 7;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_SAMPLES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 1'd1;

  // Register values after reset.
  localparam logic [COUNT_W-1:0]    NUM_SAMPLES_RESET = 7'd8;
  localparam logic [SAMPLE_W-1:0]   THRESHOLD_RESET   = 16'd2000;

  // One input item.
  typedef struct packed {
    logic [CHANNEL_W-1:0]       probe_channel;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_item_t;

  // One result item.
  typedef struct packed {
    logic [CHANNEL_W-1:0]       result_channel;
    logic signed [SAMPLE_W-1:0] average;
    logic [COUNT_W-1:0]         accepted_count;
  } result_item_t;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } oras_state_t;

endpackage

// ===== hw/rtl/oras_divider.sv =====
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
module oras_divider
  import oras_pkg::*;
#(
  parameter int DIVIDEND_W = 23,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output div_status_t           status
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      count;
  logic                  busy;
  logic                  done;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  // Control: the step counter and the busy and done flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial);
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= DIVISOR_W'(shifted);
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== hw/rtl/outlier_rejecting_sample_averager.sv =====
// Top level of the outlier-rejecting sample averager.
// Samples are taken in batches of num_samples (0 acts as 1, values above MAX_SAMPLES act as
// MAX_SAMPLES); the first sample's probe_channel names the channel of the whole batch. Each
// sample is compared with the channel's baseline (its previous batch average, or the first
// positive sample while that baseline is zero) and is summed and counted when the distance is
// below outlier_threshold. At batch end one result carries the truncated mean and the count,
// and the mean becomes the channel's new baseline. Each sample request passes through accept,
// difference and accumulate steps before the next one is taken. The last sample of a batch
// then goes through the restoring divider, which produces one quotient bit per cycle; a batch
// with no accepted sample skips the divider. A finished result waits in an output register,
// so new samples are taken while it is still stalled; a batch ending while the previous
// result is still held waits for that register to empty.
module outlier_rejecting_sample_averager
  import oras_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int MAX_SAMPLES  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // Sample channel
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_item_t           sample_data,
  // Result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_item_t           result_data,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W    = SAMPLE_W + IDX_W;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  oras_state_t state;
  oras_state_t state_next;

  logic [COUNT_W-1:0]          num_samples;
  logic [SAMPLE_W-1:0]         outlier_threshold;

  logic signed [SAMPLE_W-1:0]  channel_baseline [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0]  working_baseline;
  logic signed [SUM_W-1:0]     running_sum;
  logic [IDX_W-1:0]            valid_tally;
  logic [IDX_W-1:0]            sample_index;
  logic [CHANNEL_W-1:0]        batch_channel;

  logic signed [SAMPLE_W-1:0]  cur_sample;
  logic [SAMPLE_W:0]           diff;
  logic signed [SAMPLE_W-1:0]  average;
  logic                        sum_negative;

  logic                        in_accept;
  logic                        div_start;
  logic                        emit_write;

  logic [IDX_W-1:0]            batch_len;
  logic [IDX_W-1:0]            index_inc;
  logic                        batch_end;
  logic [CH_IDX_W-1:0]         in_slot;
  logic [CH_IDX_W-1:0]         batch_slot;
  logic                        in_has_slot;
  logic                        batch_has_slot;
  logic signed [SAMPLE_W-1:0]  eff_baseline;
  logic [SAMPLE_W:0]           abs_diff;
  logic                        sample_ok;
  logic [SUM_W-1:0]            sum_mag;
  logic [SUM_W-1:0]            quotient;
  logic [SUM_W-1:0]            signed_quo;
  div_status_t                 div_status;

  // Effective batch length and end-of-batch test.
  always_comb begin
    if (num_samples == '0) begin
      batch_len = IDX_W'(1);
    end else if (32'(num_samples) > 32'(MAX_SAMPLES)) begin
      batch_len = IDX_W'(MAX_SAMPLES);
    end else begin
      batch_len = IDX_W'(num_samples);
    end
    index_inc = sample_index + 1'b1;
    batch_end = (index_inc >= batch_len);
  end

  // Baseline slot lookup for the incoming and the current batch channel.
  always_comb begin
    in_slot        = CH_IDX_W'(sample_data.probe_channel);
    batch_slot     = CH_IDX_W'(batch_channel);
    in_has_slot    = (32'(sample_data.probe_channel) < 32'(NUM_CHANNELS));
    batch_has_slot = (32'(batch_channel) < 32'(NUM_CHANNELS));
  end

  // Baseline choice, outlier test and divider operand preparation.
  always_comb begin
    if (working_baseline == '0 && valid_tally == '0 && cur_sample > 0) begin
      eff_baseline = cur_sample;
    end else begin
      eff_baseline = working_baseline;
    end
    abs_diff     = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    sample_ok    = (abs_diff < {1'b0, outlier_threshold});
    sum_mag      = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
    signed_quo   = sum_negative ? (~quotient + 1'b1) : quotient;
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_DIFF;
      end
      ST_DIFF: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = batch_end ? ST_DIV_START : ST_IDLE;
      end
      ST_DIV_START: begin
        state_next = (valid_tally == '0) ? ST_EMIT : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_status.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_write) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    sample_stall = 1'b1;
    div_start    = 1'b0;
    emit_write   = 1'b0;
    unique case (state)
      ST_IDLE:      sample_stall = 1'b0;
      ST_DIV_START: div_start = (valid_tally != '0);
      ST_EMIT:      emit_write = !result_valid || !result_stall;
      default: begin
      end
    endcase
  end

  assign in_accept = sample_valid && !sample_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples       <= NUM_SAMPLES_RESET;
      outlier_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_SAMPLES: num_samples       <= cfg_data[COUNT_W-1:0];
        CFG_THRESHOLD:   outlier_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Batch state: baselines, running sum, tally and sample position.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) channel_baseline[i] <= '0;
      working_baseline <= '0;
      running_sum      <= '0;
      valid_tally      <= '0;
      sample_index     <= '0;
      batch_channel    <= '0;
    end else begin
      if (in_accept && sample_index == '0) begin
        batch_channel    <= sample_data.probe_channel;
        working_baseline <= in_has_slot ? channel_baseline[in_slot] : '0;
        running_sum      <= '0;
        valid_tally      <= '0;
      end
      if (state == ST_DIFF) begin
        working_baseline <= eff_baseline;
      end
      if (state == ST_ACC) begin
        if (sample_ok) begin
          running_sum <= running_sum + SUM_W'(cur_sample);
          valid_tally <= valid_tally + 1'b1;
        end
        sample_index <= batch_end ? '0 : index_inc;
      end
      if (emit_write && batch_has_slot) begin
        channel_baseline[batch_slot] <= average;
      end
    end
  end

  // Sample capture, difference register and batch average.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_sample <= sample_data.sample;
    end
    if (state == ST_DIFF) begin
      diff <= {cur_sample[SAMPLE_W-1], cur_sample} - {eff_baseline[SAMPLE_W-1], eff_baseline};
    end
    if (state == ST_DIV_START) begin
      sum_negative <= running_sum[SUM_W-1];
      average      <= '0;
    end
    if (div_status.done) begin
      average <= SAMPLE_W'(signed_quo);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_write) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_write) begin
      result_data.result_channel <= batch_channel;
      result_data.average        <= average;
      result_data.accepted_count <= COUNT_W'(valid_tally);
    end
  end

  oras_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (IDX_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (valid_tally),
    .quotient (quotient),
    .status   (div_status)
  );

  // The tally never exceeds the number of samples already taken in the batch.
  a_tally_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> (valid_tally <= sample_index))
    else $error("valid tally exceeds samples taken");

  // The divider reports completion only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == ST_DIV_WAIT))
    else $error("divider done outside wait state");

  // While waiting, the divider is either still working or finishing.
  a_wait_has_divider: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_WAIT) |-> (div_status.busy || div_status.done))
    else $error("waiting on an idle divider");

  // A result written at batch end is presented on the next cycle.
  a_emit_presents: assert property (@(posedge clk) disable iff (rst)
    emit_write |=> (result_valid && state == ST_IDLE))
    else $error("batch result not presented");

endmodule

// ===== bench/tb_outlier_rejecting_sample_averager.sv =====
// Self-checking testbench for the outlier-rejecting sample averager.
`timescale 1ns / 1ps

module tb_outlier_rejecting_sample_averager;
  import oras_pkg::*;

  localparam int MAX_SAMPLES     = 64;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 110;
  localparam int NUM_PHASES      = 16;

  // Tracks per-channel baselines and the open batch, and queues the batch averages to come.
  class averager_scoreboard;
    logic [COUNT_W-1:0]    num_samples;
    logic [CFG_DATA_W-1:0] threshold;
    int                    baseline [4];
    int                    batch_baseline;
    int                    batch_sum;
    int                    batch_tally;
    int                    batch_pos;
    logic [CHANNEL_W-1:0]  batch_chan;
    result_item_t          expected_averages [$];
    int                    failures;

    function new();
      num_samples = NUM_SAMPLES_RESET;
      threshold = THRESHOLD_RESET;
      foreach (baseline[i]) baseline[i] = 0;
      batch_baseline = 0;
      batch_sum = 0;
      batch_tally = 0;
      batch_pos = 0;
      batch_chan = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      if (index == CFG_NUM_SAMPLES) begin
        num_samples = value[COUNT_W-1:0];
      end else begin
        threshold = value;
      end
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction

    // Folds one accepted sample into the open batch; closes the batch when it is full.
    function void note_sample(sample_item_t item);
      int s;
      int gap;
      int len;
      int avg;
      result_item_t r;
      s = int'($signed(item.sample));
      if (batch_pos == 0) begin
        batch_chan = item.probe_channel;
        batch_baseline = baseline[batch_chan];
        batch_sum = 0;
        batch_tally = 0;
      end
      // An unset baseline is seeded by the first positive sample before any is accepted.
      if (batch_baseline == 0 && batch_tally == 0 && s > 0) begin
        batch_baseline = s;
      end
      gap = s - batch_baseline;
      if (gap < 0) gap = -gap;
      if (gap < int'(threshold)) begin
        batch_sum += s;
        batch_tally++;
      end
      batch_pos++;
      len = (num_samples == 0) ? 1 : (num_samples > MAX_SAMPLES) ? MAX_SAMPLES : num_samples;
      if (batch_pos >= len) begin
        avg = (batch_tally > 0) ? batch_sum / batch_tally : 0;
        baseline[batch_chan] = avg;
        r.result_channel = batch_chan;
        r.average = avg[SAMPLE_W-1:0];
        r.accepted_count = batch_tally[COUNT_W-1:0];
        expected_averages.push_back(r);
        batch_pos = 0;
      end
    endfunction

    // Compares a delivered result with the oldest expected average.
    function void check_result(result_item_t got);
      result_item_t want;
      if (expected_averages.size() == 0) begin
        $error("unexpected result: result_channel %0d average %0d accepted_count %0d",
               got.result_channel, $signed(got.average), got.accepted_count);
        failures++;
        return;
      end
      want = expected_averages.pop_front();
      if (got.result_channel !== want.result_channel) begin
        $error("result_channel: expected %0d, actual %0d", want.result_channel,
               got.result_channel);
        failures++;
      end
      if (got.average !== want.average) begin
        $error("average: expected %0d, actual %0d", $signed(want.average),
               $signed(got.average));
        failures++;
      end
      if (got.accepted_count !== want.accepted_count) begin
        $error("accepted_count: expected %0d, actual %0d", want.accepted_count,
               got.accepted_count);
        failures++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_stall;
  sample_item_t           sample_data;
  logic                   result_valid;
  logic                   result_stall;
  result_item_t           result_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count;
  averager_scoreboard board = new();

  outlier_rejecting_sample_averager dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both channels are observed at the edge at which a request or a result is taken.
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) board.note_sample(sample_data);
    if (!rst && result_valid && !result_stall) board.check_result(result_data);
  end

  // Result side: random stalls, or one long hold-off when one is requested.
  initial begin : result_sink
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one sample request, after a random idle stretch, and waits until it is taken.
  task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data.probe_channel <= ch;
    sample_data.sample <= value;
    do @(posedge clk); while (sample_stall);
  endtask

  // Writes both registers back to back; the block is idle whenever this is called.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] ns, input logic [CFG_DATA_W-1:0] thr);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NUM_SAMPLES;
    cfg_data <= ns;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(CFG_NUM_SAMPLES, ns);
    cfg_index <= CFG_THRESHOLD;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(CFG_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering requests, waits for every expected result, then lets a sample in flight finish.
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Batches whose samples mostly cluster around a level, with wild samples mixed in.
  task automatic send_random(input int n_items, input int len, input int thr);
    int center;
    int spread;
    int v;
    logic [CHANNEL_W-1:0] ch;
    logic [CHANNEL_W-1:0] probe;
    center = 1000;
    ch = '0;
    spread = (thr == 0) ? 100 : thr + thr / 2;
    for (int i = 0; i < n_items; i++) begin
      // A new batch picks its channel and usually a new level.
      if (i % len == 0) begin
        ch = CHANNEL_W'($urandom_range(3));
        if ($urandom_range(99) < 60) center = int'($urandom_range(40000)) - 8000;
      end
      if ($urandom_range(99) < 80) begin
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end else begin
        v = int'($urandom);
      end
      probe = ($urandom_range(99) < 70) ? ch : CHANNEL_W'($urandom);
      send_sample(probe, v[SAMPLE_W-1:0]);
    end
  endtask

  initial begin : stimulus
    int ns_tab [NUM_PHASES] = '{1, 4, 0, 64, 127, 8, 2, 100, 3, 16, 1, 5, 32, 7, 1, 2};
    int thr_tab [NUM_PHASES] = '{2000, 500, 65535, 3000, 1, 8000, 0, 1500,
                                 20000, 2000, 300, 65535, 4000, 1000, 2500, 6000};
    int eff;
    sample_valid = 1'b0;
    sample_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the first positive sample seeds the baseline; extremes and the
    // exact threshold distance are rejected.
    send_sample(2'd2, 16'd1000);
    send_sample(2'd1, 16'd0);
    send_sample(2'd3, 16'hFFFF);
    send_sample(2'd0, 16'h7FFF);
    send_sample(2'd2, 16'h8000);
    send_sample(2'd2, 16'd2999);
    send_sample(2'd2, 16'd3000);
    send_sample(2'd2, 16'd1100);
    settle();

    // Threshold zero rejects everything, and a zero average clears a baseline.
    load_settings(16'd1, 16'd0);
    send_sample(2'd3, 16'd7);
    send_sample(2'd2, 16'd1000);
    settle();

    // Batch length zero acts as one; the widest threshold still rejects a full-scale swing.
    load_settings(16'd0, 16'hFFFF);
    send_sample(2'd0, 16'h8000);
    send_sample(2'd0, 16'h7FFF);
    settle();

    // Batch length shortened in the middle of a batch ends it at the next sample.
    load_settings(16'd8, 16'd1);
    send_sample(2'd1, 16'd50);
    send_sample(2'd3, 16'd50);
    send_sample(2'd0, 16'd51);
    send_sample(2'd2, 16'd49);
    send_sample(2'd1, 16'hFFCE);
    settle();
    load_settings(16'd3, 16'd1);
    send_sample(2'd2, 16'd50);

    // Random phases over a range of settings and idle patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      load_settings(CFG_DATA_W'(ns_tab[p]), CFG_DATA_W'(thr_tab[p]));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      // One-sample batches with a long result hold-off fill the block up.
      if (p == 10) hold_cycles = HOLD_OFF_CYCLES;
      eff = (ns_tab[p] == 0) ? 1 : (ns_tab[p] > MAX_SAMPLES) ? MAX_SAMPLES : ns_tab[p];
      send_random(PHASE_ITEMS, eff, thr_tab[p]);
    end

    settle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/oras_pkg.sv
hw/rtl/oras_divider.sv
hw/rtl/outlier_rejecting_sample_averager.sv
bench/tb_outlier_rejecting_sample_averager.sv
